FILE: hw/rtl/sdll_pkg.sv
// ----------------------------------------------------------------------------
// sdll_pkg
// Shared constants for the static doubly linked list: default sizes,
// operation codes, status codes and stream field widths.
// ----------------------------------------------------------------------------
package sdll_pkg;

    // default sizes
    localparam int SLOTS_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // stream field widths
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 3;
    localparam int SLOT_W   = 6;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 64;

    // operation codes
    localparam logic [OP_W-1:0] OP_APPEND   = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT   = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND_POS = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND_VAL = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STAT_W-1:0] ST_RANGE   = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOMATCH = 3'd4;

endpackage

FILE: hw/rtl/static_doubly_linked_list.sv
// ----------------------------------------------------------------------------
// static_doubly_linked_list
// Array-backed doubly linked list with a LIFO free stack, held in
// synchronous memories and driven by a small sequencer.
// ----------------------------------------------------------------------------
// One word is taken at a time. Append and insert at the tail go straight
// to the link writes and then the output handshake; delete, find by
// position and insert in the middle walk from the nearer end at one node
// per cycle (one read of the link memory per cycle), and the insert then
// makes its link writes. Find by value reads every node once and pauses
// only when a match meets a full output register. Slot 0 is the sentinel
// and lives in head/tail registers; the memories need no clearing after
// reset.
module static_doubly_linked_list #(
    parameter int SLOTS      = sdll_pkg::SLOTS_DEF,
    parameter int DATA_WIDTH = sdll_pkg::DATA_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // op[2:0], position[9:3], value[41:10], zero fill
    input  logic [sdll_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[2:0], slot[8:3], data_out[40:9], prev_slot[46:41],
    // next_slot[52:47], length[58:53], zero fill
    output logic [sdll_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast
);

    localparam int AW = $clog2(SLOTS);
    localparam int SW = (DATA_WIDTH < sdll_pkg::VAL_W) ? DATA_WIDTH : sdll_pkg::VAL_W;
    localparam int CW = sdll_pkg::POS_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_LINK1  = 3'd4;
    localparam logic [2:0] S_LINK2  = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    // memories
    logic [SW-1:0] val_mem  [SLOTS];
    logic [AW-1:0] nxt_mem  [SLOTS];
    logic [AW-1:0] prv_mem  [SLOTS];
    logic [AW-1:0] free_mem [SLOTS-1];

    logic [SW-1:0] val_q;
    logic [AW-1:0] nxt_q, prv_q, free_q;

    // control and payload registers
    logic [2:0]                  state_reg, state_next;
    logic [AW-1:0]               len_reg, len_next;
    logic [AW-1:0]               fc_reg, fc_next;
    logic [AW-1:0]               head_reg, head_next;
    logic [AW-1:0]               tail_reg, tail_next;
    logic [sdll_pkg::OP_W-1:0]   op_reg;
    logic [CW-1:0]               pos_reg;
    logic [SW-1:0]               val_reg;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic                        dir_reg, dir_next;
    logic                        pend_reg, pend_next;
    logic [AW-1:0]               cur_reg;
    logic [AW-1:0]               a_reg, a_next;
    logic [AW-1:0]               b_reg, b_next;
    logic [sdll_pkg::STAT_W-1:0] res_status_reg, res_status_next;
    logic [AW-1:0]               res_slot_reg, res_slot_next;
    logic [SW-1:0]               res_data_reg, res_data_next;
    logic [AW-1:0]               res_prev_reg, res_prev_next;
    logic [AW-1:0]               res_next_reg, res_next_next;
    logic                        m_valid_reg;
    logic [sdll_pkg::M_DATA_W-1:0] m_data_reg;
    logic                        m_last_reg;

    // memory ports
    logic [AW-1:0] raddr;
    logic          val_we, nxt_we, prv_we, free_we;
    logic [AW-1:0] val_wa, nxt_wa, nxt_wd, prv_wa, prv_wd;

    logic          out_free, out_load, out_last;
    logic [CW-1:0] len7;
    logic          fwd, match;
    logic [AW-1:0] new_slot;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign out_free = !m_valid_reg || m_tready;
    assign len7     = CW'(len_reg);
    assign fwd      = (pos_reg <= (len7 >> 1));
    assign match    = (val_q == val_reg);
    assign new_slot = (fc_reg != '0) ? free_q : AW'(len_reg + 1'b1);

    // sequencer
    always_comb begin
        state_next      = state_reg;
        len_next        = len_reg;
        fc_next         = fc_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cnt_next        = cnt_reg;
        dir_next        = dir_reg;
        pend_next       = pend_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_data_next   = res_data_reg;
        res_prev_next   = res_prev_reg;
        res_next_next   = res_next_reg;
        raddr           = cur_reg;
        val_we          = 1'b0;
        val_wa          = new_slot;
        nxt_we          = 1'b0;
        nxt_wa          = '0;
        nxt_wd          = '0;
        prv_we          = 1'b0;
        prv_wa          = '0;
        prv_wd          = '0;
        free_we         = 1'b0;
        out_load        = 1'b0;
        out_last        = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                // error results carry zeros
                res_slot_next = '0;
                res_data_next = '0;
                res_prev_next = '0;
                res_next_next = '0;
                dir_next      = fwd;
                cnt_next      = fwd ? (pos_reg - 1'b1) : (len7 - pos_reg);
                unique case (op_reg)
                    sdll_pkg::OP_APPEND, sdll_pkg::OP_INSERT: begin
                        priority if (op_reg == sdll_pkg::OP_INSERT &&
                                     (pos_reg == '0 || pos_reg > len7 + 1'b1)) begin
                            res_status_next = sdll_pkg::ST_RANGE;
                            state_next      = S_EMIT;
                        end else if (len_reg >= AW'(SLOTS - 1)) begin
                            res_status_next = sdll_pkg::ST_FULL;
                            state_next      = S_EMIT;
                        end else if (op_reg == sdll_pkg::OP_APPEND ||
                                     pos_reg == len7 + 1'b1) begin
                            a_next     = tail_reg;
                            b_next     = '0;
                            state_next = S_LINK1;
                        end else begin
                            raddr      = fwd ? head_reg : tail_reg;
                            state_next = S_WALK;
                        end
                    end
                    sdll_pkg::OP_DELETE, sdll_pkg::OP_FIND_POS: begin
                        priority if (len_reg == '0) begin
                            res_status_next = sdll_pkg::ST_EMPTY;
                            state_next      = S_EMIT;
                        end else if (pos_reg == '0 || pos_reg > len7) begin
                            res_status_next = sdll_pkg::ST_RANGE;
                            state_next      = S_EMIT;
                        end else begin
                            raddr      = fwd ? head_reg : tail_reg;
                            state_next = S_WALK;
                        end
                    end
                    sdll_pkg::OP_FIND_VAL: begin
                        if (len_reg == '0) begin
                            res_status_next = sdll_pkg::ST_EMPTY;
                            state_next      = S_EMIT;
                        end else begin
                            raddr      = head_reg;
                            cnt_next   = len7;
                            pend_next  = 1'b0;
                            state_next = S_SCAN;
                        end
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_WALK: begin
                if (cnt_reg == '0) begin
                    // target node is cur_reg, its links are on the read port
                    res_status_next = sdll_pkg::ST_OK;
                    res_slot_next   = cur_reg;
                    res_data_next   = val_q;
                    res_prev_next   = prv_q;
                    res_next_next   = nxt_q;
                    unique case (op_reg)
                        sdll_pkg::OP_INSERT: begin
                            a_next     = prv_q;
                            b_next     = cur_reg;
                            state_next = S_LINK1;
                        end
                        sdll_pkg::OP_DELETE: begin
                            // unlink and push on the free stack
                            if (prv_q == '0) begin
                                head_next = nxt_q;
                            end else begin
                                nxt_we = 1'b1;
                                nxt_wa = prv_q;
                                nxt_wd = nxt_q;
                            end
                            if (nxt_q == '0) begin
                                tail_next = prv_q;
                            end else begin
                                prv_we = 1'b1;
                                prv_wa = nxt_q;
                                prv_wd = prv_q;
                            end
                            free_we    = 1'b1;
                            fc_next    = fc_reg + 1'b1;
                            len_next   = len_reg - 1'b1;
                            state_next = S_EMIT;
                        end
                        default: begin
                            state_next = S_EMIT;
                        end
                    endcase
                end else begin
                    raddr    = dir_reg ? nxt_q : prv_q;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_SCAN: begin
                // hold the node while an earlier match waits for the output
                if (!(match && pend_reg && !out_free)) begin
                    if (match) begin
                        if (pend_reg) begin
                            out_load = 1'b1;
                            out_last = 1'b0;
                        end
                        pend_next       = 1'b1;
                        res_status_next = sdll_pkg::ST_OK;
                        res_slot_next   = cur_reg;
                        res_data_next   = val_q;
                        res_prev_next   = prv_q;
                        res_next_next   = nxt_q;
                    end
                    if (cnt_reg == CW'(1)) begin
                        if (!match && !pend_reg) begin
                            res_status_next = sdll_pkg::ST_NOMATCH;
                            res_slot_next   = '0;
                            res_data_next   = '0;
                            res_prev_next   = '0;
                            res_next_next   = '0;
                        end
                        state_next = S_EMIT;
                    end else begin
                        raddr    = nxt_q;
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            S_LINK1: begin
                // write the new node
                val_we          = 1'b1;
                nxt_we          = 1'b1;
                nxt_wa          = new_slot;
                nxt_wd          = b_reg;
                prv_we          = 1'b1;
                prv_wa          = new_slot;
                prv_wd          = a_reg;
                if (fc_reg != '0) begin
                    fc_next = fc_reg - 1'b1;
                end
                res_status_next = sdll_pkg::ST_OK;
                res_slot_next   = new_slot;
                res_data_next   = val_reg;
                res_prev_next   = a_reg;
                res_next_next   = b_reg;
                state_next      = S_LINK2;
            end
            S_LINK2: begin
                // point the neighbors at the new node, length moves with head/tail
                if (a_reg == '0) begin
                    head_next = res_slot_reg;
                end else begin
                    nxt_we = 1'b1;
                    nxt_wa = a_reg;
                    nxt_wd = res_slot_reg;
                end
                if (b_reg == '0) begin
                    tail_next = res_slot_reg;
                end else begin
                    prv_we = 1'b1;
                    prv_wa = b_reg;
                    prv_wd = res_slot_reg;
                end
                len_next   = len_reg + 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // memory ports, read data registered
    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[val_wa] <= val_reg;
        end
        if (nxt_we) begin
            nxt_mem[nxt_wa] <= nxt_wd;
        end
        if (prv_we) begin
            prv_mem[prv_wa] <= prv_wd;
        end
        if (free_we) begin
            free_mem[fc_reg] <= cur_reg;
        end
        val_q  <= val_mem[raddr];
        nxt_q  <= nxt_mem[raddr];
        prv_q  <= prv_mem[raddr];
        free_q <= free_mem[fc_reg - 1'b1];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            fc_reg      <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            fc_reg    <= fc_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            pend_reg  <= pend_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg  <= s_tdata[2:0];
            pos_reg <= s_tdata[9:3];
            val_reg <= s_tdata[10 +: SW];
        end
        cur_reg         <= raddr;
        cnt_reg         <= cnt_next;
        dir_reg         <= dir_next;
        a_reg           <= a_next;
        b_reg           <= b_next;
        res_status_reg  <= res_status_next;
        res_slot_reg    <= res_slot_next;
        res_data_reg    <= res_data_next;
        res_prev_reg    <= res_prev_next;
        res_next_reg    <= res_next_next;
        if (out_load) begin
            m_data_reg <= {5'd0,
                           sdll_pkg::SLOT_W'(len_reg),
                           sdll_pkg::SLOT_W'(res_next_reg),
                           sdll_pkg::SLOT_W'(res_prev_reg),
                           sdll_pkg::VAL_W'(res_data_reg),
                           sdll_pkg::SLOT_W'(res_slot_reg),
                           res_status_reg};
            m_last_reg <= out_last;
        end
    end

    // checks
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (len_reg + fc_reg) <= AW'(SLOTS - 1))
        else $error("list length plus free count exceeds the store");

    a_head_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (len_reg == '0) == (head_reg == '0))
        else $error("head link disagrees with list length");

    a_tail_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (len_reg == '0) == (tail_reg == '0))
        else $error("tail link disagrees with list length");

    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2:0] != sdll_pkg::ST_OK) |-> m_tlast)
        else $error("error word not marked last");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK || state_reg == S_SCAN) |-> !s_tready)
        else $error("input accepted during a walk");

endmodule
